FILE: rtl/hrsp_pkg.sv
// Shared constants, types and character helpers for the HTTP request stream parser.
package hrsp_pkg;

  localparam int unsigned PhW = 5;
  localparam int unsigned TagW = 4;
  localparam int unsigned StatW = 2;
  localparam int unsigned PosW = 4;

  localparam logic [PhW-1:0] PH_START        = 5'd0;
  localparam logic [PhW-1:0] PH_METHOD       = 5'd1;
  localparam logic [PhW-1:0] PH_BEFORE_URL   = 5'd2;
  localparam logic [PhW-1:0] PH_URL          = 5'd3;
  localparam logic [PhW-1:0] PH_BEFORE_PKEY  = 5'd4;
  localparam logic [PhW-1:0] PH_PKEY         = 5'd5;
  localparam logic [PhW-1:0] PH_BEFORE_PVAL  = 5'd6;
  localparam logic [PhW-1:0] PH_PVAL         = 5'd7;
  localparam logic [PhW-1:0] PH_BEFORE_PROTO = 5'd8;
  localparam logic [PhW-1:0] PH_PROTO        = 5'd9;
  localparam logic [PhW-1:0] PH_BEFORE_VER   = 5'd10;
  localparam logic [PhW-1:0] PH_VER          = 5'd11;
  localparam logic [PhW-1:0] PH_HKEY         = 5'd12;
  localparam logic [PhW-1:0] PH_HVAL         = 5'd13;
  localparam logic [PhW-1:0] PH_GOT_CR       = 5'd14;
  localparam logic [PhW-1:0] PH_GOT_CRLF     = 5'd15;
  localparam logic [PhW-1:0] PH_GOT_CRLFCR   = 5'd16;
  localparam logic [PhW-1:0] PH_BODY         = 5'd17;
  localparam logic [PhW-1:0] PH_COMPLETE     = 5'd18;
  localparam logic [PhW-1:0] PH_INVALID      = 5'd19;

  localparam logic [TagW-1:0] TAG_NONE     = 4'd0;
  localparam logic [TagW-1:0] TAG_METHOD   = 4'd1;
  localparam logic [TagW-1:0] TAG_URL      = 4'd2;
  localparam logic [TagW-1:0] TAG_PKEY     = 4'd3;
  localparam logic [TagW-1:0] TAG_PVALUE   = 4'd4;
  localparam logic [TagW-1:0] TAG_PROTOCOL = 4'd5;
  localparam logic [TagW-1:0] TAG_VERSION  = 4'd6;
  localparam logic [TagW-1:0] TAG_HKEY     = 4'd7;
  localparam logic [TagW-1:0] TAG_HVALUE   = 4'd8;
  localparam logic [TagW-1:0] TAG_BODY     = 4'd9;

  localparam logic [StatW-1:0] ST_PARSING  = 2'd0;
  localparam logic [StatW-1:0] ST_COMPLETE = 2'd1;
  localparam logic [StatW-1:0] ST_INVALID  = 2'd2;

  localparam logic [PosW-1:0] NAME_LEN = 4'd14;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             in_field;
    logic [TagW-1:0]  field_tag;
    logic             field_close;
    logic [TagW-1:0]  closed_tag;
    logic [StatW-1:0] status;
  } res_t;

  function automatic logic [7:0] name_char(input logic [PosW-1:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43;  // C
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h6E;  // n
      4'd3:    ch = 8'h74;  // t
      4'd4:    ch = 8'h65;  // e
      4'd5:    ch = 8'h6E;  // n
      4'd6:    ch = 8'h74;  // t
      4'd7:    ch = 8'h2D;  // -
      4'd8:    ch = 8'h4C;  // L
      4'd9:    ch = 8'h65;  // e
      4'd10:   ch = 8'h6E;  // n
      4'd11:   ch = 8'h67;  // g
      4'd12:   ch = 8'h74;  // t
      4'd13:   ch = 8'h68;  // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

FILE: rtl/hrsp_fsm.sv
// Parser state machine with header name matcher and length tracking.
module hrsp_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 kind_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output hrsp_pkg::res_t       res_o
);

  logic [hrsp_pkg::PhW-1:0]  phase_q, phase_d;
  logic [hrsp_pkg::PosW-1:0] pos_q, pos_d;
  logic alive_q, alive_d;
  logic seen_q, seen_d;
  logic nonzero_q, nonzero_d;
  logic digits_q, digits_d;
  logic skip_q, skip_d;

  logic                      cont, close;
  logic [hrsp_pkg::TagW-1:0] tag, ctag;
  logic                      match_ok, first_ok, matched;
  logic [7:0]                c;

  assign c        = data_byte_i;
  assign match_ok = alive_q && (pos_q < hrsp_pkg::NAME_LEN) &&
                    (c == hrsp_pkg::name_char(pos_q));
  assign first_ok = (c == hrsp_pkg::name_char('0));
  assign matched  = alive_q && (pos_q == hrsp_pkg::NAME_LEN);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    alive_d   = alive_q;
    seen_d    = seen_q;
    nonzero_d = nonzero_q;
    digits_d  = digits_q;
    skip_d    = skip_q;
    cont      = 1'b0;
    close     = 1'b0;
    tag       = hrsp_pkg::TAG_NONE;
    ctag      = hrsp_pkg::TAG_NONE;
    if (kind_i) begin
      phase_d   = hrsp_pkg::PH_START;
      pos_d     = '0;
      alive_d   = 1'b1;
      seen_d    = 1'b0;
      nonzero_d = 1'b0;
      digits_d  = 1'b1;
      skip_d    = 1'b0;
    end else begin
      case (phase_q)
        hrsp_pkg::PH_START: begin
          if (c == hrsp_pkg::CH_CR || c == hrsp_pkg::CH_LF || hrsp_pkg::is_blank(c)) begin
            phase_d = hrsp_pkg::PH_START;
          end else if (hrsp_pkg::is_upper(c)) begin
            phase_d = hrsp_pkg::PH_METHOD;
            cont    = 1'b1;
            tag     = hrsp_pkg::TAG_METHOD;
          end else begin
            phase_d = hrsp_pkg::PH_INVALID;
          end
        end
        hrsp_pkg::PH_METHOD: begin
          if (hrsp_pkg::is_upper(c)) begin
            cont = 1'b1;
            tag  = hrsp_pkg::TAG_METHOD;
          end else if (hrsp_pkg::is_blank(c)) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_METHOD;
            phase_d = hrsp_pkg::PH_BEFORE_URL;
          end else begin
            phase_d = hrsp_pkg::PH_INVALID;
          end
        end
        hrsp_pkg::PH_BEFORE_URL: begin
          if (c == hrsp_pkg::CH_SLASH) begin
            phase_d = hrsp_pkg::PH_URL;
            cont    = 1'b1;
            tag     = hrsp_pkg::TAG_URL;
          end else if (!hrsp_pkg::is_blank(c)) begin
            phase_d = hrsp_pkg::PH_INVALID;
          end
        end
        hrsp_pkg::PH_URL: begin
          if (c == hrsp_pkg::CH_QUEST) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_URL;
            phase_d = hrsp_pkg::PH_BEFORE_PKEY;
          end else if (hrsp_pkg::is_blank(c)) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_URL;
            phase_d = hrsp_pkg::PH_BEFORE_PROTO;
          end else begin
            cont = 1'b1;
            tag  = hrsp_pkg::TAG_URL;
          end
        end
        hrsp_pkg::PH_BEFORE_PKEY: begin
          if (hrsp_pkg::is_blank(c) || c == hrsp_pkg::CH_CR || c == hrsp_pkg::CH_LF) begin
            phase_d = hrsp_pkg::PH_INVALID;
          end else begin
            phase_d = hrsp_pkg::PH_PKEY;
            cont    = 1'b1;
            tag     = hrsp_pkg::TAG_PKEY;
          end
        end
        hrsp_pkg::PH_PKEY: begin
          if (c == hrsp_pkg::CH_EQUAL) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_PKEY;
            phase_d = hrsp_pkg::PH_BEFORE_PVAL;
          end else if (hrsp_pkg::is_blank(c)) begin
            phase_d = hrsp_pkg::PH_INVALID;
          end else begin
            cont = 1'b1;
            tag  = hrsp_pkg::TAG_PKEY;
          end
        end
        hrsp_pkg::PH_BEFORE_PVAL: begin
          if (hrsp_pkg::is_blank(c) || c == hrsp_pkg::CH_CR || c == hrsp_pkg::CH_LF) begin
            phase_d = hrsp_pkg::PH_INVALID;
          end else begin
            phase_d = hrsp_pkg::PH_PVAL;
            cont    = 1'b1;
            tag     = hrsp_pkg::TAG_PVALUE;
          end
        end
        hrsp_pkg::PH_PVAL: begin
          if (c == hrsp_pkg::CH_AMP) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_PVALUE;
            phase_d = hrsp_pkg::PH_BEFORE_PKEY;
          end else if (hrsp_pkg::is_blank(c)) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_PVALUE;
            phase_d = hrsp_pkg::PH_BEFORE_PROTO;
          end else begin
            cont = 1'b1;
            tag  = hrsp_pkg::TAG_PVALUE;
          end
        end
        hrsp_pkg::PH_BEFORE_PROTO: begin
          if (!hrsp_pkg::is_blank(c)) begin
            phase_d = hrsp_pkg::PH_PROTO;
            cont    = 1'b1;
            tag     = hrsp_pkg::TAG_PROTOCOL;
          end
        end
        hrsp_pkg::PH_PROTO: begin
          if (c == hrsp_pkg::CH_SLASH) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_PROTOCOL;
            phase_d = hrsp_pkg::PH_BEFORE_VER;
          end else begin
            cont = 1'b1;
            tag  = hrsp_pkg::TAG_PROTOCOL;
          end
        end
        hrsp_pkg::PH_BEFORE_VER: begin
          if (hrsp_pkg::is_digit(c)) begin
            phase_d = hrsp_pkg::PH_VER;
            cont    = 1'b1;
            tag     = hrsp_pkg::TAG_VERSION;
          end else begin
            phase_d = hrsp_pkg::PH_INVALID;
          end
        end
        hrsp_pkg::PH_VER: begin
          if (c == hrsp_pkg::CH_CR) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_VERSION;
            phase_d = hrsp_pkg::PH_GOT_CR;
          end else if (hrsp_pkg::is_digit(c) || c == hrsp_pkg::CH_DOT) begin
            cont = 1'b1;
            tag  = hrsp_pkg::TAG_VERSION;
          end else begin
            phase_d = hrsp_pkg::PH_INVALID;
          end
        end
        hrsp_pkg::PH_GOT_CR: begin
          phase_d = (c == hrsp_pkg::CH_LF) ? hrsp_pkg::PH_GOT_CRLF : hrsp_pkg::PH_INVALID;
        end
        hrsp_pkg::PH_GOT_CRLF: begin
          if (c == hrsp_pkg::CH_CR) begin
            phase_d = hrsp_pkg::PH_GOT_CRLFCR;
          end else if (hrsp_pkg::is_blank(c)) begin
            phase_d = hrsp_pkg::PH_INVALID;
          end else begin
            phase_d = hrsp_pkg::PH_HKEY;
            cont    = 1'b1;
            tag     = hrsp_pkg::TAG_HKEY;
            pos_d   = first_ok ? hrsp_pkg::PosW'(1) : '0;
            alive_d = first_ok;
          end
        end
        hrsp_pkg::PH_HKEY: begin
          if (c == hrsp_pkg::CH_COLON) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_HKEY;
            phase_d = hrsp_pkg::PH_HVAL;
            skip_d  = 1'b1;
            if (matched) begin
              seen_d    = 1'b1;
              nonzero_d = 1'b0;
              digits_d  = 1'b1;
            end
          end else begin
            cont = 1'b1;
            tag  = hrsp_pkg::TAG_HKEY;
            if (match_ok) begin
              pos_d = pos_q + hrsp_pkg::PosW'(1);
            end else begin
              alive_d = 1'b0;
            end
          end
        end
        hrsp_pkg::PH_HVAL: begin
          if (c == hrsp_pkg::CH_CR) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_HVALUE;
            phase_d = hrsp_pkg::PH_GOT_CR;
            skip_d  = 1'b0;
          end else if (!(skip_q && hrsp_pkg::is_blank(c))) begin
            skip_d = 1'b0;
            cont   = 1'b1;
            tag    = hrsp_pkg::TAG_HVALUE;
            if (matched && digits_q) begin
              if (!hrsp_pkg::is_digit(c)) begin
                digits_d = 1'b0;
              end else if (c != hrsp_pkg::CH_ZERO) begin
                nonzero_d = 1'b1;
              end
            end
          end
        end
        hrsp_pkg::PH_GOT_CRLFCR: begin
          if (c != hrsp_pkg::CH_LF) begin
            phase_d = hrsp_pkg::PH_INVALID;
          end else if (last_byte_i || (seen_q && !nonzero_q)) begin
            phase_d = hrsp_pkg::PH_COMPLETE;
          end else begin
            phase_d = hrsp_pkg::PH_BODY;
          end
        end
        hrsp_pkg::PH_BODY: begin
          cont = 1'b1;
          tag  = hrsp_pkg::TAG_BODY;
          if (last_byte_i) begin
            close   = 1'b1;
            ctag    = hrsp_pkg::TAG_BODY;
            phase_d = hrsp_pkg::PH_COMPLETE;
          end
        end
        hrsp_pkg::PH_COMPLETE, hrsp_pkg::PH_INVALID: begin
          phase_d = phase_q;
        end
        default: begin
          phase_d = hrsp_pkg::PH_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    res_o.out_byte    = c;
    res_o.in_field    = cont;
    res_o.field_tag   = tag;
    res_o.field_close = close;
    res_o.closed_tag  = ctag;
    if (phase_d == hrsp_pkg::PH_COMPLETE) begin
      res_o.status = hrsp_pkg::ST_COMPLETE;
    end else if (phase_d == hrsp_pkg::PH_INVALID) begin
      res_o.status = hrsp_pkg::ST_INVALID;
    end else begin
      res_o.status = hrsp_pkg::ST_PARSING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= hrsp_pkg::PH_START;
      pos_q     <= '0;
      alive_q   <= 1'b1;
      seen_q    <= 1'b0;
      nonzero_q <= 1'b0;
      digits_q  <= 1'b1;
      skip_q    <= 1'b0;
    end else if (push_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      alive_q   <= alive_d;
      seen_q    <= seen_d;
      nonzero_q <= nonzero_d;
      digits_q  <= digits_d;
      skip_q    <= skip_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= hrsp_pkg::NAME_LEN)
    else $error("header match position out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && kind_i) |=> (phase_q == hrsp_pkg::PH_START && !seen_q))
    else $error("restart did not return parser to start");

  a_final_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !kind_i && (phase_q == hrsp_pkg::PH_COMPLETE ||
     phase_q == hrsp_pkg::PH_INVALID)) |=> (phase_q == $past(phase_q)))
    else $error("final phase left without restart");

endmodule

FILE: rtl/hrsp_out_buf.sv
// Result register with skid stage between the parser and the output channel.
module hrsp_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrsp_pkg::res_t res_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           ready_i,
  output hrsp_pkg::res_t res_o
);

  logic           main_v_q, skid_v_q;
  hrsp_pkg::res_t main_q, skid_q;
  logic           pop;

  assign pop     = main_v_q && ready_i;
  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign res_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= res_i;
      end
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without a result in front");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && pop) |=> (main_v_q && !skid_v_q && main_q == $past(skid_q)))
    else $error("skid entry not moved forward on pop");

endmodule

FILE: rtl/http_request_stream_parser_unit.sv
// Top level of the byte-serial HTTP request stream parser.
// Each accepted request's result is registered in the output buffer (main entry, or skid entry when stalled).
// Throughput: one request per cycle while in_ready_o is high, that is while the skid entry is free.
// A two-entry result buffer keeps input ready during an output stall until its skid entry is full.
// Reset (rst_ni low, asynchronous) puts the parser in its start state, empties the buffer.
module http_request_stream_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       in_field_o,
  output logic [3:0] field_tag_o,
  output logic       field_close_o,
  output logic [3:0] closed_tag_o,
  output logic [1:0] status_o
);

  logic           push;
  hrsp_pkg::res_t res_new, res_out;

  assign push = in_valid_i && in_ready_o;

  hrsp_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_o       (res_new)
  );

  hrsp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_new),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign out_byte_o    = res_out.out_byte;
  assign in_field_o    = res_out.in_field;
  assign field_tag_o   = res_out.field_tag;
  assign field_close_o = res_out.field_close;
  assign closed_tag_o  = res_out.closed_tag;
  assign status_o      = res_out.status;

endmodule
